>>> rtl/core/rwa_pkg.sv
// Package: shared types, codes and constants for the relocatable word ALU
`default_nettype none
package rwa_pkg;
    localparam int WORD_W = 48;
    localparam int HALF_W = 24;
    localparam int SEG_W = 4;
    localparam int MODE_W = 4;
    localparam int STATUS_W = 2;
    localparam int SHIFT_W = 6;
    localparam int SEGMENT_TAGS_DEF = 16;

    localparam logic [MODE_W-1:0] OP_ADD    = 4'd0;
    localparam logic [MODE_W-1:0] OP_SUB    = 4'd1;
    localparam logic [MODE_W-1:0] OP_AND    = 4'd2;
    localparam logic [MODE_W-1:0] OP_OR     = 4'd3;
    localparam logic [MODE_W-1:0] OP_XOR    = 4'd4;
    localparam logic [MODE_W-1:0] OP_XORNOT = 4'd5;
    localparam logic [MODE_W-1:0] OP_SHL    = 4'd6;
    localparam logic [MODE_W-1:0] OP_SHR    = 4'd7;
    localparam logic [MODE_W-1:0] OP_MUL    = 4'd8;
    localparam logic [MODE_W-1:0] OP_DIV    = 4'd9;
    localparam logic [MODE_W-1:0] OP_MOD    = 4'd10;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd2;

    // Result kind carried down the pipe
    typedef enum logic [1:0] {
        K_LOGIC = 2'd0,
        K_MUL   = 2'd1,
        K_DIV   = 2'd2,
        K_MOD   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [WORD_W-1:0]    val;
        logic [SEG_W-1:0]     seg;
        logic [STATUS_W-1:0]  status;
    } ctl_t;
endpackage
`default_nettype wire

>>> rtl/core/rwa_decode.sv
// Decode stage: relocation checks and the add, subtract, logic and shift operations
`default_nettype none
module rwa_decode #(
    parameter int SEGMENT_TAGS = rwa_pkg::SEGMENT_TAGS_DEF
) (
    input  wire logic [rwa_pkg::MODE_W-1:0] mode,
    input  wire logic [rwa_pkg::WORD_W-1:0] a,
    input  wire logic [rwa_pkg::SEG_W-1:0]  sa_raw,
    input  wire logic [rwa_pkg::WORD_W-1:0] b,
    input  wire logic [rwa_pkg::SEG_W-1:0]  sb_raw,
    output rwa_pkg::ctl_t                   ctl
);
    import rwa_pkg::*;

    logic [SEG_W-1:0] tag_tab [1 << SEG_W];
    logic [SEG_W-1:0] sa, sb;
    logic [SHIFT_W-1:0] sh;
    logic bz;

    // tag reduction as a constant lookup over every raw tag
    for (genvar i = 0; i < (1 << SEG_W); i++)
    begin : g_tag
        assign tag_tab[i] = SEG_W'(i % SEGMENT_TAGS);
    end

    always_comb
    begin
        sa = tag_tab[sa_raw];
        sb = tag_tab[sb_raw];
        sh = b[SHIFT_W-1:0];
        bz = (b[HALF_W-1:0] == '0);
        ctl.kind = K_LOGIC;
        ctl.val = '0;
        ctl.seg = '0;
        ctl.status = ST_OK;
        if (mode == OP_ADD)
        begin
            if (sa != '0 && sb != '0)
                ctl.status = ST_COMPLEX;
            else
            begin
                ctl.seg = (sa == '0) ? sb : sa;
                ctl.val = a + b;
            end
        end
        else if (mode == OP_SUB)
        begin
            if (sb != '0)
                ctl.status = ST_COMPLEX;
            else
            begin
                ctl.seg = sa;
                ctl.val = a - b;
            end
        end
        else if (sa != '0 || sb != '0)
            ctl.status = ST_COMPLEX;
        else
        begin
            case (mode)
                OP_AND:    ctl.val = a & b;
                OP_OR:     ctl.val = a | b;
                OP_XOR:    ctl.val = a ^ b;
                OP_XORNOT: ctl.val = a ^ ~b;
                OP_SHL:    ctl.val = a << sh;
                OP_SHR:    ctl.val = a >> sh;
                OP_MUL:    ctl.kind = K_MUL;
                OP_DIV:
                begin
                    if (bz) ctl.status = ST_DIVZERO;
                    else ctl.kind = K_DIV;
                end
                OP_MOD:
                begin
                    if (bz) ctl.status = ST_DIVZERO;
                    else ctl.kind = K_MOD;
                end
                default:   ctl.val = a;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/rwa_divpipe.sv
// Pipelined 24-bit restoring divider, STEP quotient bits per stage
`default_nettype none
module rwa_divpipe #(
    parameter int STAGES = 6
) (
    input  wire logic                       clk,
    input  wire logic                       adv,
    input  wire logic [rwa_pkg::HALF_W-1:0] num,
    input  wire logic [rwa_pkg::HALF_W-1:0] den,
    output logic      [rwa_pkg::HALF_W-1:0] quo,
    output logic      [rwa_pkg::HALF_W-1:0] rem
);
    import rwa_pkg::*;
    localparam int STEP = HALF_W / STAGES;

    logic [HALF_W-1:0] q_reg [1:STAGES];
    logic [HALF_W-1:0] r_reg [1:STAGES];
    logic [HALF_W-1:0] d_reg [1:STAGES-1];

    for (genvar s = 0; s < STAGES; s++)
    begin : g_st
        logic [HALF_W-1:0] q_in, r_in, d_in;
        logic [HALF_W-1:0] q_next, r_next;
        logic [HALF_W:0] t;

        if (s == 0)
        begin : g_first
            assign q_in = num;
            assign r_in = '0;
            assign d_in = den;
        end
        else
        begin : g_rest
            assign q_in = q_reg[s];
            assign r_in = r_reg[s];
            assign d_in = d_reg[s];
        end

        always_comb
        begin
            q_next = q_in;
            r_next = r_in;
            t = '0;
            for (int i = 0; i < STEP; i++)
            begin
                t = {r_next, q_next[HALF_W-1]};
                q_next = {q_next[HALF_W-2:0], 1'b0};
                if (t >= {1'b0, d_in})
                begin
                    t = t - {1'b0, d_in};
                    q_next[0] = 1'b1;
                end
                r_next = t[HALF_W-1:0];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                q_reg[s+1] <= q_next;
                r_reg[s+1] <= r_next;
            end
        end

        // the last stage has no use for the divisor
        if (s < STAGES - 1)
        begin : g_den
            always_ff @(posedge clk)
            begin
                if (adv)
                    d_reg[s+1] <= d_in;
            end
        end
    end

    assign quo = q_reg[STAGES];
    assign rem = r_reg[STAGES];
endmodule
`default_nettype wire

>>> rtl/core/relocatable_word_alu.sv
// Top level: pipelined tagged 48-bit ALU with relocation checks
// Usage:
//   Input channel in_valid/in_stall carries mode, operands and segment tags;
//   output channel out_valid/out_stall carries result_value, result_segment
//   and status. A transfer happens when valid is high and stall is low.
//   The path from the input transfer to out_valid runs through one decode
//   register, six divider stages (four quotient bits each; the 24x24
//   multiply is held in a registered product alongside) and one output
//   register, the decode register loading at the input transfer.
//   One item per cycle is sustained while the output is not stalled.
//   Stages advance together whenever the output register is free or being
//   taken, so a stall holds every stage with its valid bit and nothing is
//   lost or repeated. in_stall is the output stall, passed back only when the
//   output register is full. Reset clears all valid bits; the pipe is empty
//   after reset and takes an item in the first cycle.
`default_nettype none
module relocatable_word_alu #(
    parameter int SEGMENT_TAGS = rwa_pkg::SEGMENT_TAGS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [rwa_pkg::MODE_W-1:0]    mode,
    input  wire logic [rwa_pkg::WORD_W-1:0]    left_value,
    input  wire logic [rwa_pkg::SEG_W-1:0]     left_segment,
    input  wire logic [rwa_pkg::WORD_W-1:0]    right_value,
    input  wire logic [rwa_pkg::SEG_W-1:0]     right_segment,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [rwa_pkg::WORD_W-1:0]    result_value,
    output logic      [rwa_pkg::SEG_W-1:0]     result_segment,
    output logic      [rwa_pkg::STATUS_W-1:0]  status
);
    import rwa_pkg::*;
    localparam int DSTAGES = 6;
    localparam int DEPTH = DSTAGES + 1;

    logic adv;
    ctl_t dec;
    ctl_t ctl_reg [DEPTH];
    logic [DEPTH-1:0] v_reg;
    logic [HALF_W-1:0] al_reg, bl_reg;
    logic [WORD_W-1:0] prod_reg [DSTAGES];
    logic [HALF_W-1:0] quo, rem;
    logic out_valid_reg;
    logic [WORD_W-1:0] val_reg;
    logic [SEG_W-1:0] seg_reg;
    logic [STATUS_W-1:0] st_reg;
    logic [WORD_W-1:0] val_next;

    assign adv = !out_valid_reg || !out_stall;
    assign in_stall = !adv;

    rwa_decode #(.SEGMENT_TAGS(SEGMENT_TAGS)) u_dec (
        .mode(mode), .a(left_value), .sa_raw(left_segment),
        .b(right_value), .sb_raw(right_segment), .ctl(dec)
    );

    rwa_divpipe #(.STAGES(DSTAGES)) u_div (
        .clk(clk), .adv(adv), .num(al_reg), .den(bl_reg),
        .quo(quo), .rem(rem)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
            out_valid_reg <= v_reg[DEPTH-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= dec;
            al_reg <= left_value[HALF_W-1:0];
            bl_reg <= right_value[HALF_W-1:0];
            prod_reg[0] <= WORD_W'(al_reg) * WORD_W'(bl_reg);
            for (int i = 1; i < DEPTH; i++)
                ctl_reg[i] <= ctl_reg[i-1];
            for (int i = 1; i < DSTAGES; i++)
                prod_reg[i] <= prod_reg[i-1];
            val_reg <= val_next;
            seg_reg <= ctl_reg[DEPTH-1].seg;
            st_reg <= ctl_reg[DEPTH-1].status;
        end
    end

    always_comb
    begin
        case (ctl_reg[DEPTH-1].kind)
            K_MUL:   val_next = prod_reg[DSTAGES-1];
            K_DIV:   val_next = {{(WORD_W-HALF_W){1'b0}}, quo};
            K_MOD:   val_next = {{(WORD_W-HALF_W){1'b0}}, rem};
            default: val_next = ctl_reg[DEPTH-1].val;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign result_value = val_reg;
    assign result_segment = seg_reg;
    assign status = st_reg;

`ifndef SYNTH
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> result_value == '0 && result_segment == '0)
        else $error("error result not cleared");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_value))
        else $error("stalled result changed");
    a_st_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3)
        else $error("bad status");
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(v_reg))
        else $error("pipe moved while stalled");
`endif
endmodule
`default_nettype wire
